// File: hdl/manhattan_ring_cell_enumerator_assert.svh
// Assertion macros used by the checker file.
`ifndef MANHATTAN_RING_CELL_ENUMERATOR_ASSERT_SVH
`define MANHATTAN_RING_CELL_ENUMERATOR_ASSERT_SVH

// Same-cycle implication.
`define MRCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mrce: same-cycle check failed");

// Next-cycle implication.
`define MRCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mrce: next-cycle check failed");

`endif

// File: hdl/mrce_pkg.sv
package mrce_pkg;

    localparam int MAX_DIM = 256;

    localparam int CFG_W   = 9;
    localparam int COORD_W = 8;
    localparam int DIST_W  = 9;
    localparam int STEP_W  = DIST_W + 1;
    localparam int MAXD_W  = DIST_W + 1;
    localparam int CNT_W   = 17;
    localparam int PROD_W  = 2 * CFG_W;
    localparam int POS_W   = 12;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] CFG_GRID_ROWS  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_GRID_COLS  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CENTER_ROW = 2'd2;
    localparam logic [IDX_W-1:0] CFG_CENTER_COL = 2'd3;

    typedef enum logic [1:0] {
        PH_CENTER,
        PH_BOTTOM,
        PH_PAIRS,
        PH_TOP
    } t_phase;

    typedef enum logic {
        ST_IDLE,
        ST_SEARCH
    } t_state;

    typedef struct packed {
        logic start;
        logic step;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic resolve;
        logic slot_free;
    } t_sts;

    // zero acts as one, anything above the largest grid acts as the largest
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (v > CFG_W'(MAX_DIM)) begin
            res = CFG_W'(MAX_DIM);
        end
        return res;
    endfunction

endpackage

// File: hdl/mrce_if.sv
interface mrce_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface mrce_res_if;
    logic                             valid;
    logic                             ready;
    logic [mrce_pkg::COORD_W-1:0]     cell_row;
    logic [mrce_pkg::COORD_W-1:0]     cell_col;
    logic [mrce_pkg::DIST_W-1:0]      distance;
    logic                             valid_res;
    logic                             last;

    modport source (output valid, output cell_row, output cell_col, output distance,
                    output valid_res, output last, input ready);
    modport sink (input valid, input cell_row, input cell_col, input distance,
                  input valid_res, input last, output ready);
endinterface

// File: hdl/manhattan_ring_cell_enumerator.sv
// After a request is taken, the walk skips each ring point outside the grid, one
// candidate per cycle, and then loads the registered result word.
// A new request is taken only once the previous one has loaded its result word; it is taken
// while the previous result word still waits in the output register.
// Reset (synchronous, active low): walk at the center, grid 1x1, center (0,0).
module manhattan_ring_cell_enumerator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mrce_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [mrce_pkg::CFG_W-1:0]     i_cfg_data,
    mrce_req_if.sink                       i_req,
    mrce_res_if.source                     o_res
);

    mrce_pkg::t_cmd cmd;
    mrce_pkg::t_sts sts;
    logic           req_ready;

    mrce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mrce_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_restart   (i_req.restart),
        .o_sts       (sts),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_cell_row  (o_res.cell_row),
        .o_cell_col  (o_res.cell_col),
        .o_distance  (o_res.distance),
        .o_valid_res (o_res.valid_res),
        .o_last      (o_res.last)
    );

    assign i_req.ready = req_ready;

endmodule

// File: hdl/mrce_ctrl.sv
module mrce_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  mrce_pkg::t_sts i_sts,
    output mrce_pkg::t_cmd o_cmd
);

    mrce_pkg::t_state r_state;
    mrce_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrce_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mrce_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_state = mrce_pkg::ST_SEARCH;
                end
            end
            mrce_pkg::ST_SEARCH: begin
                if (i_sts.resolve && i_sts.slot_free) begin
                    n_state = mrce_pkg::ST_IDLE;
                end
            end
            default: n_state = mrce_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        case (r_state)
            mrce_pkg::ST_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.start = i_req_valid;
            end
            mrce_pkg::ST_SEARCH: begin
                // skip ring points one per cycle; hold when the result word can't be placed
                o_cmd.step = !i_sts.resolve;
                o_cmd.load = i_sts.resolve && i_sts.slot_free;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/mrce_dpath.sv
module mrce_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mrce_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [mrce_pkg::CFG_W-1:0]     i_cfg_data,
    input  mrce_pkg::t_cmd                 i_cmd,
    input  logic                           i_restart,
    output mrce_pkg::t_sts                 o_sts,
    input  logic                           i_res_ready,
    output logic                           o_res_valid,
    output logic [mrce_pkg::COORD_W-1:0]   o_cell_row,
    output logic [mrce_pkg::COORD_W-1:0]   o_cell_col,
    output logic [mrce_pkg::DIST_W-1:0]    o_distance,
    output logic                           o_valid_res,
    output logic                           o_last
);

    localparam int PD = mrce_pkg::POS_W;

    // configuration registers
    logic [mrce_pkg::CFG_W-1:0]   r_grid_rows;
    logic [mrce_pkg::CFG_W-1:0]   r_grid_cols;
    logic [mrce_pkg::COORD_W-1:0] r_center_row;
    logic [mrce_pkg::COORD_W-1:0] r_center_col;

    // per-run geometry, latched when a word is accepted
    logic [mrce_pkg::CFG_W-1:0]   r_rows;
    logic [mrce_pkg::CFG_W-1:0]   r_cols;
    logic [mrce_pkg::COORD_W-1:0] r_r0;
    logic [mrce_pkg::COORD_W-1:0] r_c0;
    logic [mrce_pkg::MAXD_W-1:0]  r_maxd;
    logic [mrce_pkg::CNT_W-1:0]   r_total;

    // walk state
    mrce_pkg::t_phase             r_phase;
    mrce_pkg::t_phase             n_phase;
    logic [mrce_pkg::DIST_W-1:0]  r_ring_distance;
    logic [mrce_pkg::DIST_W-1:0]  n_ring_distance;
    logic [mrce_pkg::STEP_W-1:0]  r_ring_step;
    logic [mrce_pkg::STEP_W-1:0]  n_ring_step;
    logic                         r_pair_side;
    logic                         n_pair_side;
    logic [mrce_pkg::CNT_W-1:0]   r_count;
    logic                         r_finished;

    // result word
    logic                         r_res_vld;
    logic [mrce_pkg::COORD_W-1:0] r_cell_row;
    logic [mrce_pkg::COORD_W-1:0] r_cell_col;
    logic [mrce_pkg::DIST_W-1:0]  r_distance;
    logic                         r_valid_res;
    logic                         r_last;

    logic [mrce_pkg::CFG_W-1:0]   eff_rows;
    logic [mrce_pkg::CFG_W-1:0]   eff_cols;
    logic [mrce_pkg::CFG_W-1:0]   lim_row;
    logic [mrce_pkg::CFG_W-1:0]   lim_col;
    logic [mrce_pkg::COORD_W-1:0] clamp_r0;
    logic [mrce_pkg::COORD_W-1:0] clamp_c0;
    logic [mrce_pkg::PROD_W-1:0]  prod;

    logic signed [PD-1:0]         d_s;
    logic signed [PD-1:0]         k_s;
    logic signed [PD-1:0]         off_s;
    logic signed [PD-1:0]         abs_s;
    logic signed [PD-1:0]         m_s;
    logic signed [PD-1:0]         dr_s;
    logic signed [PD-1:0]         dc_s;
    logic signed [PD-1:0]         row_s;
    logic signed [PD-1:0]         col_s;
    logic [mrce_pkg::DIST_W-1:0]  cand_dist;
    logic [mrce_pkg::STEP_W-1:0]  step_inc;
    logic [mrce_pkg::CNT_W-1:0]   cnt_inc;
    logic                         hit;
    logic                         exhaust;
    logic                         advance;
    logic                         take_hit;
    logic                         is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= mrce_pkg::CFG_W'(1);
            r_grid_cols  <= mrce_pkg::CFG_W'(1);
            r_center_row <= '0;
            r_center_col <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mrce_pkg::CFG_GRID_ROWS:  r_grid_rows  <= i_cfg_data;
                mrce_pkg::CFG_GRID_COLS:  r_grid_cols  <= i_cfg_data;
                mrce_pkg::CFG_CENTER_ROW: r_center_row <= i_cfg_data[mrce_pkg::COORD_W-1:0];
                mrce_pkg::CFG_CENTER_COL: r_center_col <= i_cfg_data[mrce_pkg::COORD_W-1:0];
                default: r_grid_rows <= r_grid_rows;
            endcase
        end
    end

    always_comb begin
        eff_rows = mrce_pkg::eff_dim(r_grid_rows);
        eff_cols = mrce_pkg::eff_dim(r_grid_cols);
        lim_row  = eff_rows - mrce_pkg::CFG_W'(1);
        lim_col  = eff_cols - mrce_pkg::CFG_W'(1);
        clamp_r0 = ({1'b0, r_center_row} > lim_row) ? lim_row[mrce_pkg::COORD_W-1:0]
                                                   : r_center_row;
        clamp_c0 = ({1'b0, r_center_col} > lim_col) ? lim_col[mrce_pkg::COORD_W-1:0]
                                                   : r_center_col;
        prod     = eff_rows * eff_cols;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_rows  <= eff_rows;
            r_cols  <= eff_cols;
            r_r0    <= clamp_r0;
            r_c0    <= clamp_c0;
            r_maxd  <= {1'b0, eff_rows} + {1'b0, eff_cols} - mrce_pkg::MAXD_W'(2);
            r_total <= prod[mrce_pkg::CNT_W-1:0];
        end
    end

    // candidate ring point for the current walk position
    always_comb begin
        d_s   = $signed({{(PD-mrce_pkg::DIST_W){1'b0}}, r_ring_distance});
        k_s   = $signed({{(PD-mrce_pkg::STEP_W){1'b0}}, r_ring_step});
        off_s = d_s - k_s;
        abs_s = off_s[PD-1] ? -off_s : off_s;
        m_s   = d_s - abs_s;
        dr_s  = '0;
        dc_s  = '0;
        cand_dist = r_ring_distance;
        case (r_phase)
            mrce_pkg::PH_CENTER: begin
                cand_dist = '0;
            end
            mrce_pkg::PH_BOTTOM: begin
                dr_s = d_s;
            end
            mrce_pkg::PH_PAIRS: begin
                dr_s = off_s;
                dc_s = r_pair_side ? -m_s : m_s;
            end
            mrce_pkg::PH_TOP: begin
                dr_s = -d_s;
            end
            default: begin
                cand_dist = '0;
            end
        endcase
        row_s = $signed({{(PD-mrce_pkg::COORD_W){1'b0}}, r_r0}) + dr_s;
        col_s = $signed({{(PD-mrce_pkg::COORD_W){1'b0}}, r_c0}) + dc_s;
        hit   = !row_s[PD-1] && (row_s < $signed({{(PD-mrce_pkg::CFG_W){1'b0}}, r_rows}))
             && !col_s[PD-1] && (col_s < $signed({{(PD-mrce_pkg::CFG_W){1'b0}}, r_cols}));
        exhaust = (r_phase != mrce_pkg::PH_CENTER) && ({1'b0, r_ring_distance} > r_maxd);
    end

    // walk successor
    always_comb begin
        n_phase         = r_phase;
        n_ring_distance = r_ring_distance;
        n_ring_step     = r_ring_step;
        n_pair_side     = r_pair_side;
        step_inc        = r_ring_step + mrce_pkg::STEP_W'(1);
        case (r_phase)
            mrce_pkg::PH_CENTER: begin
                n_phase         = mrce_pkg::PH_BOTTOM;
                n_ring_distance = mrce_pkg::DIST_W'(1);
            end
            mrce_pkg::PH_BOTTOM: begin
                n_phase     = mrce_pkg::PH_PAIRS;
                n_ring_step = mrce_pkg::STEP_W'(1);
                n_pair_side = 1'b0;
            end
            mrce_pkg::PH_PAIRS: begin
                n_pair_side = !r_pair_side;
                if (r_pair_side) begin
                    n_ring_step = step_inc;
                    // pair index runs 1 .. 2d-1
                    if (step_inc >= {r_ring_distance, 1'b0}) begin
                        n_phase = mrce_pkg::PH_TOP;
                    end
                end
            end
            mrce_pkg::PH_TOP: begin
                n_phase         = mrce_pkg::PH_BOTTOM;
                n_ring_distance = r_ring_distance + mrce_pkg::DIST_W'(1);
            end
            default: n_phase = mrce_pkg::PH_CENTER;
        endcase
    end

    assign cnt_inc  = r_count + mrce_pkg::CNT_W'(1);
    assign is_last  = cnt_inc >= r_total;
    assign take_hit = i_cmd.load && !r_finished && !exhaust;
    assign advance  = i_cmd.step || take_hit;

    assign o_sts.resolve   = r_finished || exhaust || hit;
    assign o_sts.slot_free = !r_res_vld || i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= mrce_pkg::PH_CENTER;
            r_ring_distance <= '0;
            r_ring_step     <= '0;
            r_pair_side     <= 1'b0;
            r_count         <= '0;
            r_finished      <= 1'b0;
        end else if (i_cmd.start && i_restart) begin
            r_phase         <= mrce_pkg::PH_CENTER;
            r_ring_distance <= '0;
            r_ring_step     <= '0;
            r_pair_side     <= 1'b0;
            r_count         <= '0;
            r_finished      <= 1'b0;
        end else begin
            if (advance) begin
                r_phase         <= n_phase;
                r_ring_distance <= n_ring_distance;
                r_ring_step     <= n_ring_step;
                r_pair_side     <= n_pair_side;
            end
            if (i_cmd.load && !r_finished) begin
                if (exhaust) begin
                    r_finished <= 1'b1;
                end else begin
                    r_count    <= cnt_inc;
                    r_finished <= is_last;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_res_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (take_hit) begin
                r_cell_row  <= row_s[mrce_pkg::COORD_W-1:0];
                r_cell_col  <= col_s[mrce_pkg::COORD_W-1:0];
                r_distance  <= cand_dist;
                r_valid_res <= 1'b1;
                r_last      <= is_last;
            end else begin
                r_cell_row  <= '0;
                r_cell_col  <= '0;
                r_distance  <= '0;
                r_valid_res <= 1'b0;
                r_last      <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_res_vld;
    assign o_cell_row  = r_cell_row;
    assign o_cell_col  = r_cell_col;
    assign o_distance  = r_distance;
    assign o_valid_res = r_valid_res;
    assign o_last      = r_last;

endmodule

// File: hdl/mrce_chk.sv
`include "manhattan_ring_cell_enumerator_assert.svh"

module mrce_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_req_valid,
    input logic                           i_req_ready,
    input logic                           i_res_valid,
    input logic                           i_res_ready,
    input logic [mrce_pkg::COORD_W-1:0]   i_cell_row,
    input logic [mrce_pkg::COORD_W-1:0]   i_cell_col,
    input logic [mrce_pkg::DIST_W-1:0]    i_distance,
    input logic                           i_valid_res,
    input logic                           i_last
);

    // a result word stays offered until taken
    `MRCE_ASSERT_NXT(a_res_hold, i_clk, i_rst_n, i_res_valid && !i_res_ready, i_res_valid)

    // one request at a time: busy right after a word is taken
    `MRCE_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // an invalid result carries all zero fields
    `MRCE_ASSERT_IMP(a_invalid_zero, i_clk, i_rst_n, i_res_valid && !i_valid_res, (i_cell_row == '0) && (i_cell_col == '0) && (i_distance == '0) && !i_last)

    // last only ever marks a real cell
    `MRCE_ASSERT_IMP(a_last_is_cell, i_clk, i_rst_n, i_res_valid && i_last, i_valid_res)

endmodule

bind manhattan_ring_cell_enumerator mrce_chk u_mrce_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_cell_row  (o_res.cell_row),
    .i_cell_col  (o_res.cell_col),
    .i_distance  (o_res.distance),
    .i_valid_res (o_res.valid_res),
    .i_last      (o_res.last)
);

// File: test/manhattan_ring_cell_enumerator_tb.sv
module manhattan_ring_cell_enumerator_tb;

    localparam int HALF_PERIOD    = 6;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_ITEMS   = 1750;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [mrce_pkg::COORD_W-1:0] cell_row;
        logic [mrce_pkg::COORD_W-1:0] cell_col;
        logic [mrce_pkg::DIST_W-1:0]  distance;
        logic                         valid_res;
        logic                         last_cell;
    } t_cell_word;

    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        logic [mrce_pkg::IDX_W-1:0] idx;
        logic [mrce_pkg::CFG_W-1:0] data;
        logic                       restart;
        bit                         typed;
        t_cell_word                 want;
    } t_stim_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [mrce_pkg::IDX_W-1:0] i_cfg_idx;
    logic [mrce_pkg::CFG_W-1:0] i_cfg_data;

    mrce_req_if req_if ();
    mrce_res_if res_if ();

    manhattan_ring_cell_enumerator u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    // shadow of the block: registers and walk position
    logic [mrce_pkg::CFG_W-1:0]   grid_rows_m;
    logic [mrce_pkg::CFG_W-1:0]   grid_cols_m;
    logic [mrce_pkg::COORD_W-1:0] center_row_m;
    logic [mrce_pkg::COORD_W-1:0] center_col_m;
    logic [mrce_pkg::DIST_W-1:0]  ring_d;
    mrce_pkg::t_phase             ring_ph;
    logic [mrce_pkg::STEP_W-1:0]  ring_k;
    logic                         side_neg;
    logic [mrce_pkg::CNT_W-1:0]   emitted;
    logic                         walk_done;

    t_cell_word pending_cells[$];
    t_stim_row  typed_cells[$];
    t_stim_row  stim_table[$];

    int mismatch_count;
    int idle_cycles;
    int src_idle_pct;
    int snk_idle_pct;
    int hold_requests;
    int hold_seen;
    int hold_left;

    initial begin
        i_clk = 1'b0;
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic int eff_size(input logic [mrce_pkg::CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > mrce_pkg::MAX_DIM) begin
            return mrce_pkg::MAX_DIM;
        end
        return int'(v);
    endfunction

    function automatic void clear_walk();
        ring_d    = '0;
        ring_ph   = mrce_pkg::PH_CENTER;
        ring_k    = '0;
        side_neg  = 1'b0;
        emitted   = '0;
        walk_done = 1'b0;
    endfunction

    // next cell of the diamond walk; out-of-grid points are skipped
    function automatic t_cell_word walk_next_cell(input logic rs);
        int rows, cols, r0, c0, maxd, d, k, off, m, dr, dc, dist_v, r, c;
        t_cell_word w;
        w    = '0;
        rows = eff_size(grid_rows_m);
        cols = eff_size(grid_cols_m);
        r0   = int'(center_row_m);
        c0   = int'(center_col_m);
        if (r0 > rows - 1) begin
            r0 = rows - 1;
        end
        if (c0 > cols - 1) begin
            c0 = cols - 1;
        end
        maxd = rows + cols - 2;
        if (rs) begin
            clear_walk();
        end
        if (walk_done) begin
            return w;
        end
        while (1) begin
            if (ring_ph == mrce_pkg::PH_CENTER) begin
                dr      = 0;
                dc      = 0;
                dist_v  = 0;
                ring_ph = mrce_pkg::PH_BOTTOM;
                ring_d  = mrce_pkg::DIST_W'(1);
            end else begin
                d = int'(ring_d);
                if (d > maxd) begin
                    walk_done = 1'b1;
                    return w;
                end
                dist_v = d;
                case (ring_ph)
                    mrce_pkg::PH_BOTTOM: begin
                        dr       = d;
                        dc       = 0;
                        ring_ph  = mrce_pkg::PH_PAIRS;
                        ring_k   = mrce_pkg::STEP_W'(1);
                        side_neg = 1'b0;
                    end
                    mrce_pkg::PH_PAIRS: begin
                        k   = int'(ring_k);
                        off = d - k;
                        m   = d - ((off < 0) ? -off : off);
                        dr  = off;
                        dc  = side_neg ? -m : m;
                        if (!side_neg) begin
                            side_neg = 1'b1;
                        end else begin
                            side_neg = 1'b0;
                            ring_k   = ring_k + 1'b1;
                            if (int'(ring_k) > 2 * d - 1) begin
                                ring_ph = mrce_pkg::PH_TOP;
                            end
                        end
                    end
                    default: begin
                        dr      = -d;
                        dc      = 0;
                        ring_ph = mrce_pkg::PH_BOTTOM;
                        ring_d  = ring_d + 1'b1;
                    end
                endcase
            end
            r = r0 + dr;
            c = c0 + dc;
            if (r >= 0 && r < rows && c >= 0 && c < cols) begin
                emitted     = emitted + 1'b1;
                w.cell_row  = r[mrce_pkg::COORD_W-1:0];
                w.cell_col  = c[mrce_pkg::COORD_W-1:0];
                w.distance  = dist_v[mrce_pkg::DIST_W-1:0];
                w.valid_res = 1'b1;
                if (int'(emitted) >= rows * cols) begin
                    w.last_cell = 1'b1;
                    walk_done   = 1'b1;
                end
                return w;
            end
        end
        return w;
    endfunction

    task automatic flag_mismatch(input string what);
        $display("ERROR %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic void add_cfg(input logic [mrce_pkg::IDX_W-1:0] idx,
                                    input logic [mrce_pkg::CFG_W-1:0] data);
        t_stim_row row;
        row        = '{kind: ROW_CFG, default: '0};
        row.idx    = idx;
        row.data   = data;
        stim_table = {stim_table, row};
    endfunction

    function automatic void add_req(input logic rs);
        t_stim_row row;
        row         = '{kind: ROW_REQ, default: '0};
        row.restart = rs;
        stim_table  = {stim_table, row};
    endfunction

    function automatic void add_typed(input logic rs, input int r, input int c, input int d,
                                      input logic vr, input logic lst);
        t_stim_row row;
        row                = '{kind: ROW_REQ, default: '0};
        row.restart        = rs;
        row.typed          = 1'b1;
        row.want.cell_row  = r[mrce_pkg::COORD_W-1:0];
        row.want.cell_col  = c[mrce_pkg::COORD_W-1:0];
        row.want.distance  = d[mrce_pkg::DIST_W-1:0];
        row.want.valid_res = vr;
        row.want.last_cell = lst;
        stim_table         = {stim_table, row};
    endfunction

    // one request word, with random gaps before it
    task automatic request_cell(input logic rs);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_if.valid   <= 1'b0;
            req_if.restart <= 1'($urandom_range(0, 1));
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.restart <= rs;
        @(posedge i_clk);
        while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1)) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        req_if.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_cells.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [mrce_pkg::IDX_W-1:0] idx,
                             input logic [mrce_pkg::CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            mrce_pkg::CFG_GRID_ROWS:  grid_rows_m  = data;
            mrce_pkg::CFG_GRID_COLS:  grid_cols_m  = data;
            mrce_pkg::CFG_CENTER_ROW: center_row_m = data[mrce_pkg::COORD_W-1:0];
            default:                  center_col_m = data[mrce_pkg::COORD_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // receiver: random stalls, plus a long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            res_if.ready <= 1'b0;
            hold_left--;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cell_word predicted;
        t_cell_word got;
        t_cell_word want;
        t_stim_row  tag;
        bit         moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (req_if.valid && req_if.ready) begin
                predicted = walk_next_cell(req_if.restart);
                if (typed_cells.size() != 0) begin
                    tag = typed_cells.pop_front();
                    if (tag.typed) begin
                        predicted = tag.want;
                    end
                end
                pending_cells = {pending_cells, predicted};
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                got = {res_if.cell_row, res_if.cell_col, res_if.distance,
                       res_if.valid_res, res_if.last};
                if (pending_cells.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word row %0d col %0d dist %0d",
                                            got.cell_row, got.cell_col, got.distance));
                end else begin
                    want = pending_cells.pop_front();
                    if (got.cell_row !== want.cell_row) begin
                        flag_mismatch($sformatf("cell_row %0d, want %0d",
                                                got.cell_row, want.cell_row));
                    end
                    if (got.cell_col !== want.cell_col) begin
                        flag_mismatch($sformatf("cell_col %0d, want %0d",
                                                got.cell_col, want.cell_col));
                    end
                    if (got.distance !== want.distance) begin
                        flag_mismatch($sformatf("distance %0d, want %0d",
                                                got.distance, want.distance));
                    end
                    if (got.valid_res !== want.valid_res) begin
                        flag_mismatch($sformatf("valid_res %b, want %b",
                                                got.valid_res, want.valid_res));
                    end
                    if (got.last_cell !== want.last_cell) begin
                        flag_mismatch($sformatf("last %b, want %b",
                                                got.last_cell, want.last_cell));
                    end
                end
                moved = 1'b1;
            end
            if (i_cfg_we) begin
                moved = 1'b1;
            end
            if (moved) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        int                         phase_no;
        int                         random_sent;
        int                         pick;
        int                         rows_e;
        int                         cols_e;
        int                         cells;
        int                         n_items;
        bit                         mid_run;
        logic [mrce_pkg::CFG_W-1:0] rows_w;
        logic [mrce_pkg::CFG_W-1:0] cols_w;
        logic [mrce_pkg::CFG_W-1:0] crow_w;
        logic [mrce_pkg::CFG_W-1:0] ccol_w;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        req_if.valid   = 1'b0;
        req_if.restart = 1'b0;
        res_if.ready   = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        hold_requests  = 0;
        hold_seen      = 0;
        hold_left      = 0;
        src_idle_pct   = 29;
        snk_idle_pct   = 63;
        grid_rows_m    = mrce_pkg::CFG_W'(1);
        grid_cols_m    = mrce_pkg::CFG_W'(1);
        center_row_m   = '0;
        center_col_m   = '0;
        clear_walk();

        // 1x1 grid after reset: center is also the last cell, then finished
        add_typed(1'b0, 0, 0, 0, 1'b1, 1'b1);
        add_typed(1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_typed(1'b1, 0, 0, 0, 1'b1, 1'b1);
        // zero rows acts as one, 511 cols as MAX_DIM, center row clamped
        add_cfg(mrce_pkg::CFG_GRID_ROWS, 9'd0);
        add_cfg(mrce_pkg::CFG_GRID_COLS, 9'd511);
        add_cfg(mrce_pkg::CFG_CENTER_ROW, 9'd255);
        add_cfg(mrce_pkg::CFG_CENTER_COL, 9'd255);
        add_typed(1'b1, 0, 255, 0, 1'b1, 1'b0);
        add_typed(1'b0, 0, 254, 1, 1'b1, 1'b0);
        add_typed(1'b0, 0, 253, 2, 1'b1, 1'b0);
        add_req(1'b0);
        // 3x3 around the middle: every ring phase, last flag, then finished
        add_cfg(mrce_pkg::CFG_GRID_ROWS, 9'd3);
        add_cfg(mrce_pkg::CFG_GRID_COLS, 9'd3);
        add_cfg(mrce_pkg::CFG_CENTER_ROW, 9'd1);
        add_cfg(mrce_pkg::CFG_CENTER_COL, 9'd1);
        add_typed(1'b1, 1, 1, 0, 1'b1, 1'b0);
        add_typed(1'b0, 2, 1, 1, 1'b1, 1'b0);
        add_typed(1'b0, 1, 2, 1, 1'b1, 1'b0);
        add_typed(1'b0, 1, 0, 1, 1'b1, 1'b0);
        add_typed(1'b0, 0, 1, 1, 1'b1, 1'b0);
        add_typed(1'b0, 2, 2, 2, 1'b1, 1'b0);
        add_typed(1'b0, 2, 0, 2, 1'b1, 1'b0);
        add_typed(1'b0, 0, 2, 2, 1'b1, 1'b0);
        add_typed(1'b0, 0, 0, 2, 1'b1, 1'b1);
        add_typed(1'b0, 0, 0, 0, 1'b0, 1'b0);
        add_typed(1'b1, 1, 1, 0, 1'b1, 1'b0);
        add_typed(1'b0, 2, 1, 1, 1'b1, 1'b0);
        // grid shrinks mid-walk, no restart
        add_cfg(mrce_pkg::CFG_GRID_ROWS, 9'd1);
        add_req(1'b0);
        add_req(1'b0);
        add_req(1'b0);
        // full size grid, center in the far corner
        add_cfg(mrce_pkg::CFG_GRID_ROWS, 9'd256);
        add_cfg(mrce_pkg::CFG_GRID_COLS, 9'd256);
        add_cfg(mrce_pkg::CFG_CENTER_ROW, 9'd255);
        add_cfg(mrce_pkg::CFG_CENTER_COL, 9'd255);
        add_typed(1'b1, 255, 255, 0, 1'b1, 1'b0);
        add_typed(1'b0, 255, 254, 1, 1'b1, 1'b0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                settle_block();
                write_reg(stim_table[i].idx, stim_table[i].data);
            end else begin
                typed_cells = {typed_cells, stim_table[i]};
                request_cell(stim_table[i].restart);
            end
        end

        phase_no    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (random_sent < RANDOM_ITEMS / 3) begin
                src_idle_pct = 29;
                snk_idle_pct = 63;
            end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
                src_idle_pct = 63;
                snk_idle_pct = 29;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            pick = (phase_no == 1) ? 10 : $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3, 4, 5: begin
                    rows_w = mrce_pkg::CFG_W'($urandom_range(1, 12));
                    cols_w = mrce_pkg::CFG_W'($urandom_range(1, 12));
                end
                6: begin
                    rows_w = $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(1, 20));
                    cols_w = (rows_w == 0) ? 9'($urandom_range(1, 20)) : 9'd0;
                end
                7: begin
                    // long strip: many skipped ring points per word
                    if ($urandom_range(0, 1)) begin
                        rows_w = mrce_pkg::CFG_W'($urandom_range(256, 511));
                        cols_w = mrce_pkg::CFG_W'($urandom_range(1, 3));
                    end else begin
                        rows_w = mrce_pkg::CFG_W'($urandom_range(1, 3));
                        cols_w = mrce_pkg::CFG_W'($urandom_range(256, 511));
                    end
                end
                8: begin
                    rows_w = mrce_pkg::CFG_W'($urandom_range(1, 511));
                    cols_w = mrce_pkg::CFG_W'($urandom_range(1, 511));
                end
                9: begin
                    rows_w = mrce_pkg::CFG_W'($urandom_range(1, 40));
                    cols_w = mrce_pkg::CFG_W'($urandom_range(1, 40));
                end
                default: begin
                    rows_w = 9'd6;
                    cols_w = 9'd6;
                end
            endcase
            rows_e = eff_size(rows_w);
            cols_e = eff_size(cols_w);
            if ($urandom_range(0, 1)) begin
                crow_w = mrce_pkg::CFG_W'($urandom_range(0, (rows_e < 255) ? rows_e : 255));
                ccol_w = mrce_pkg::CFG_W'($urandom_range(0, (cols_e < 255) ? cols_e : 255));
            end else begin
                crow_w = mrce_pkg::CFG_W'($urandom_range(0, 255));
                ccol_w = mrce_pkg::CFG_W'($urandom_range(0, 255));
            end
            // keep walking from the old position only on small grids
            mid_run = (rows_e <= 16 && cols_e <= 16 && $urandom_range(0, 4) == 0);
            settle_block();
            write_reg(mrce_pkg::CFG_GRID_ROWS, rows_w);
            write_reg(mrce_pkg::CFG_GRID_COLS, cols_w);
            write_reg(mrce_pkg::CFG_CENTER_ROW, crow_w);
            write_reg(mrce_pkg::CFG_CENTER_COL, ccol_w);
            cells = rows_e * cols_e;
            if (cells <= 200) begin
                n_items = ($urandom_range(0, 3) == 0) ? $urandom_range(1, cells)
                                                      : cells + $urandom_range(0, 3);
            end else begin
                n_items = $urandom_range(40, 150);
            end
            if (pick == 10) begin
                src_idle_pct = 0;
                n_items      = cells + 4;
                hold_requests++;
            end
            for (int j = 0; j < n_items; j++) begin
                request_cell((j == 0) ? !mid_run : ($urandom_range(0, 39) == 0));
                random_sent++;
            end
            phase_no++;
        end

        req_if.valid <= 1'b0;
        while (pending_cells.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
